FILE: rtl/mss_pkg.sv
// types and constants shared by the measurement session sequencer
`timescale 1ns / 1ps

package mss_pkg;

   localparam int unsigned PULSE_BITS   = 16;
   localparam int unsigned TIMEOUT_BITS = 20;
   localparam int unsigned VALUE_BITS   = 8;
   localparam int unsigned FAULT_BITS   = 16;
   localparam int unsigned CSR_IDX_BITS = 2;

   localparam logic [PULSE_BITS-1:0]   PULSE_TICKS_RESET    = 16'd600;
   localparam logic [TIMEOUT_BITS-1:0] MEASURE_TIMEOUT_RESET  = 20'd120000;
   localparam logic [TIMEOUT_BITS-1:0] SHUTDOWN_TIMEOUT_RESET = 20'd120000;
   localparam logic signed [FAULT_BITS-1:0] FAULT_SILENT = -16'sd1;

   typedef enum logic [2:0] {
      OP_TICK      = 3'd0,
      OP_START     = 3'd1,
      OP_RESET     = 3'd2,
      OP_STATUS    = 3'd3,
      OP_RESULT    = 3'd4,
      OP_DONE      = 3'd5,
      OP_ERROR     = 3'd6,
      OP_POWERDOWN = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      REP_NONE     = 3'd0,
      REP_READY    = 3'd1,
      REP_RESULT   = 3'd2,
      REP_ERROR    = 3'd3,
      REP_NORESULT = 3'd4,
      REP_NOTREADY = 3'd5,
      REP_STATUS   = 3'd6
   } report_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_TRIGGER   = 3'd1,
      PH_MEASURING = 3'd2,
      PH_SHUTDOWN  = 3'd3,
      PH_DONE      = 3'd4
   } phase_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PULSE_TICKS      = 2'd0,
      CSR_MEASURE_TIMEOUT  = 2'd1,
      CSR_SHUTDOWN_TIMEOUT = 2'd2
   } csr_index_type;

endpackage

FILE: rtl/mss_if.sv
// handshake interfaces for event, report and register write beats
`timescale 1ns / 1ps

interface mss_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [2:0]                           operation;
   logic [mss_pkg::VALUE_BITS-1:0]       systolic_in;
   logic [mss_pkg::VALUE_BITS-1:0]       diastolic_in;
   logic [mss_pkg::VALUE_BITS-1:0]       pulse_rate_in;
   logic signed [mss_pkg::FAULT_BITS-1:0] fault_code_in;

   modport source (output valid, operation, systolic_in, diastolic_in, pulse_rate_in,
                   fault_code_in, input ready);
   modport sink (input valid, operation, systolic_in, diastolic_in, pulse_rate_in,
                 fault_code_in, output ready);
endinterface

interface mss_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [2:0]                           report;
   logic [mss_pkg::VALUE_BITS-1:0]       systolic_out;
   logic [mss_pkg::VALUE_BITS-1:0]       diastolic_out;
   logic [mss_pkg::VALUE_BITS-1:0]       pulse_rate_out;
   logic signed [mss_pkg::FAULT_BITS-1:0] fault_code_out;
   logic [2:0]                           phase_out;
   logic                                 trigger_low;

   modport source (output valid, report, systolic_out, diastolic_out, pulse_rate_out,
                   fault_code_out, phase_out, trigger_low, input ready);
   modport sink (input valid, report, systolic_out, diastolic_out, pulse_rate_out,
                 fault_code_out, phase_out, trigger_low, output ready);
endinterface

interface mss_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [mss_pkg::CSR_IDX_BITS-1:0]     reg_index;
   logic [mss_pkg::TIMEOUT_BITS-1:0]     wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink (input valid, reg_index, wr_data, output ready);
endinterface

FILE: rtl/measurement_session_sequencer.sv
// measurement session sequencer top level
//
//  channel   dir  handshake            payload
//  req_bus   in   valid/ready          operation, result bytes, fault code
//  rsp_bus   out  valid/ready          report, result bytes, fault code, phase, trigger
//  csr_bus   in   valid/ready (=1)     reg_index, wr_data
//
// one event beat in, one report beat out in the next cycle; one beat per cycle unless
// stalled; the report register is the only stage, refilled while its beat is taken
// reset (synchronous) enters idle, releases trigger, loads register defaults
// a stalled report holds the event side; register writes are always taken
`timescale 1ns / 1ps

module measurement_session_sequencer #(
   parameter int unsigned TIMER_BITS = 20
) (
   input  logic     clock,
   input  logic     reset,
   mss_req_if.sink  req_bus,
   mss_rsp_if.source rsp_bus,
   mss_csr_if.sink  csr_bus
);

   localparam int unsigned CMP_BITS =
      (TIMER_BITS > mss_pkg::TIMEOUT_BITS) ? TIMER_BITS : mss_pkg::TIMEOUT_BITS;

   // configuration
   logic [mss_pkg::PULSE_BITS-1:0]   pulse_ticks_ff;
   logic [mss_pkg::TIMEOUT_BITS-1:0] measure_timeout_ff;
   logic [mss_pkg::TIMEOUT_BITS-1:0] shutdown_timeout_ff;

   // session state
   mss_pkg::phase_type               phase_ff, phase_in;
   logic [TIMER_BITS-1:0]            phase_elapsed_ff, phase_elapsed_in;
   logic                             pulse_active_ff, pulse_active_in;
   logic [mss_pkg::PULSE_BITS-1:0]   pulse_elapsed_ff, pulse_elapsed_in;
   logic                             result_held_ff, result_held_in;
   logic [mss_pkg::VALUE_BITS-1:0]   held_sys_ff, held_sys_in;
   logic [mss_pkg::VALUE_BITS-1:0]   held_dia_ff, held_dia_in;
   logic [mss_pkg::VALUE_BITS-1:0]   held_rate_ff, held_rate_in;

   // report register
   logic                             rsp_valid_ff;
   mss_pkg::report_type              report_ff, report_in;
   logic [mss_pkg::VALUE_BITS-1:0]   sys_out_ff, sys_out_in;
   logic [mss_pkg::VALUE_BITS-1:0]   dia_out_ff, dia_out_in;
   logic [mss_pkg::VALUE_BITS-1:0]   rate_out_ff, rate_out_in;
   logic signed [mss_pkg::FAULT_BITS-1:0] fault_out_ff, fault_out_in;

   logic                             req_take;
   mss_pkg::op_type                  op;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign op            = mss_pkg::op_type'(req_bus.operation);

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ticks_ff      <= mss_pkg::PULSE_TICKS_RESET;
         measure_timeout_ff  <= mss_pkg::MEASURE_TIMEOUT_RESET;
         shutdown_timeout_ff <= mss_pkg::SHUTDOWN_TIMEOUT_RESET;
      end else if (csr_bus.valid) begin
         unique case (mss_pkg::csr_index_type'(csr_bus.reg_index))
            mss_pkg::CSR_PULSE_TICKS:
               pulse_ticks_ff <= csr_bus.wr_data[mss_pkg::PULSE_BITS-1:0];
            mss_pkg::CSR_MEASURE_TIMEOUT:  measure_timeout_ff  <= csr_bus.wr_data;
            mss_pkg::CSR_SHUTDOWN_TIMEOUT: shutdown_timeout_ff <= csr_bus.wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      phase_elapsed_in = phase_elapsed_ff;
      pulse_active_in  = pulse_active_ff;
      pulse_elapsed_in = pulse_elapsed_ff;
      result_held_in   = result_held_ff;
      held_sys_in      = held_sys_ff;
      held_dia_in      = held_dia_ff;
      held_rate_in     = held_rate_ff;
      report_in        = mss_pkg::REP_NONE;
      sys_out_in       = '0;
      dia_out_in       = '0;
      rate_out_in      = '0;
      fault_out_in     = '0;

      unique case (op)
         mss_pkg::OP_TICK: begin
            if (phase_elapsed_ff != '1) begin
               phase_elapsed_in = phase_elapsed_ff + 1'b1;
            end
            if (pulse_active_ff && pulse_elapsed_ff != '1) begin
               pulse_elapsed_in = pulse_elapsed_ff + 1'b1;
            end
            if (phase_ff == mss_pkg::PH_TRIGGER) begin
               if (!pulse_active_ff) begin
                  pulse_active_in  = 1'b1;
                  pulse_elapsed_in = '0;
               end
               if (pulse_elapsed_in >= pulse_ticks_ff) begin
                  pulse_active_in  = 1'b0;
                  phase_in         = mss_pkg::PH_MEASURING;
                  phase_elapsed_in = '0;
               end
            end
            // watchdogs
            if (phase_in == mss_pkg::PH_MEASURING &&
                CMP_BITS'(phase_elapsed_in) >= CMP_BITS'(measure_timeout_ff)) begin
               pulse_active_in  = 1'b0;
               report_in        = mss_pkg::REP_ERROR;
               fault_out_in     = mss_pkg::FAULT_SILENT;
               phase_in         = mss_pkg::PH_IDLE;
               phase_elapsed_in = '0;
            end else if (phase_in == mss_pkg::PH_SHUTDOWN &&
                  CMP_BITS'(phase_elapsed_in) >= CMP_BITS'(shutdown_timeout_ff)) begin
               report_in        = mss_pkg::REP_READY;
               result_held_in   = 1'b0;
               phase_in         = mss_pkg::PH_IDLE;
               phase_elapsed_in = '0;
            end
         end
         mss_pkg::OP_START: begin
            if (phase_ff == mss_pkg::PH_IDLE || phase_ff == mss_pkg::PH_DONE) begin
               result_held_in   = 1'b0;
               phase_elapsed_in = '0;
               if (!pulse_active_ff) begin
                  pulse_elapsed_in = '0;
               end
               if (pulse_elapsed_in >= pulse_ticks_ff) begin
                  pulse_active_in = 1'b0;
                  phase_in        = mss_pkg::PH_MEASURING;
               end else begin
                  pulse_active_in = 1'b1;
                  phase_in        = mss_pkg::PH_TRIGGER;
               end
            end else begin
               report_in = mss_pkg::REP_NOTREADY;
            end
         end
         mss_pkg::OP_RESET: begin
            pulse_active_in  = 1'b0;
            result_held_in   = 1'b0;
            phase_in         = mss_pkg::PH_IDLE;
            phase_elapsed_in = '0;
            report_in        = mss_pkg::REP_READY;
         end
         mss_pkg::OP_STATUS: begin
            report_in = mss_pkg::REP_STATUS;
         end
         mss_pkg::OP_RESULT: begin
            if (phase_ff == mss_pkg::PH_MEASURING && !result_held_ff) begin
               held_sys_in    = req_bus.systolic_in;
               held_dia_in    = req_bus.diastolic_in;
               held_rate_in   = req_bus.pulse_rate_in;
               result_held_in = 1'b1;
            end
         end
         mss_pkg::OP_DONE: begin
            if (phase_ff == mss_pkg::PH_MEASURING) begin
               if (result_held_ff) begin
                  report_in   = mss_pkg::REP_RESULT;
                  sys_out_in  = held_sys_ff;
                  dia_out_in  = held_dia_ff;
                  rate_out_in = held_rate_ff;
               end else begin
                  report_in = mss_pkg::REP_NORESULT;
               end
               phase_in         = mss_pkg::PH_SHUTDOWN;
               phase_elapsed_in = '0;
            end
         end
         mss_pkg::OP_ERROR: begin
            if (phase_ff == mss_pkg::PH_MEASURING && req_bus.fault_code_in != '0) begin
               report_in        = mss_pkg::REP_ERROR;
               fault_out_in     = req_bus.fault_code_in;
               phase_in         = mss_pkg::PH_SHUTDOWN;
               phase_elapsed_in = '0;
            end
         end
         mss_pkg::OP_POWERDOWN: begin
            if (phase_ff == mss_pkg::PH_SHUTDOWN) begin
               report_in        = mss_pkg::REP_READY;
               result_held_in   = 1'b0;
               phase_in         = mss_pkg::PH_DONE;
               phase_elapsed_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= mss_pkg::PH_IDLE;
         phase_elapsed_ff <= '0;
         pulse_active_ff  <= 1'b0;
         pulse_elapsed_ff <= '0;
         result_held_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (req_take) begin
            phase_ff         <= phase_in;
            phase_elapsed_ff <= phase_elapsed_in;
            pulse_active_ff  <= pulse_active_in;
            pulse_elapsed_ff <= pulse_elapsed_in;
            result_held_ff   <= result_held_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff     <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         held_sys_ff  <= held_sys_in;
         held_dia_ff  <= held_dia_in;
         held_rate_ff <= held_rate_in;
         report_ff    <= report_in;
         sys_out_ff   <= sys_out_in;
         dia_out_ff   <= dia_out_in;
         rate_out_ff  <= rate_out_in;
         fault_out_ff <= fault_out_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.report         = report_ff;
   assign rsp_bus.systolic_out   = sys_out_ff;
   assign rsp_bus.diastolic_out  = dia_out_ff;
   assign rsp_bus.pulse_rate_out = rate_out_ff;
   assign rsp_bus.fault_code_out = fault_out_ff;
   assign rsp_bus.phase_out      = phase_ff;
   assign rsp_bus.trigger_low    = pulse_active_ff;

endmodule

FILE: tb/mss_session_checker.sv
// checker that predicts and compares report beats of the measurement session sequencer
`timescale 1ns / 1ps

module mss_session_checker #(
   parameter int unsigned TIMER_BITS = 20
) (
   input  logic        clock,
   input  logic        reset,
   mss_req_if          req_bus,
   mss_rsp_if          rsp_bus,
   mss_csr_if          csr_bus,
   output int unsigned mismatch_count,
   output int unsigned pending_reports
);

   typedef struct packed {
      mss_pkg::report_type                    report;
      logic [mss_pkg::VALUE_BITS-1:0]         systolic;
      logic [mss_pkg::VALUE_BITS-1:0]         diastolic;
      logic [mss_pkg::VALUE_BITS-1:0]         pulse_rate;
      logic signed [mss_pkg::FAULT_BITS-1:0]  fault;
      mss_pkg::phase_type                     phase;
      logic                                   trigger_low;
   } report_beat_type;

   report_beat_type expected_reports [$];
   int unsigned     mismatches = 0;
   int unsigned     pending = 0;

   logic [mss_pkg::PULSE_BITS-1:0]   pulse_limit;
   logic [mss_pkg::TIMEOUT_BITS-1:0] measure_limit;
   logic [mss_pkg::TIMEOUT_BITS-1:0] shutdown_limit;

   mss_pkg::phase_type             phase;
   logic [TIMER_BITS-1:0]          phase_elapsed;
   logic                           pulse_active;
   logic [mss_pkg::PULSE_BITS-1:0] pulse_elapsed;
   logic                           result_held;
   logic [mss_pkg::VALUE_BITS-1:0] held_systolic;
   logic [mss_pkg::VALUE_BITS-1:0] held_diastolic;
   logic [mss_pkg::VALUE_BITS-1:0] held_pulse_rate;

   assign mismatch_count  = mismatches;
   assign pending_reports = pending;

   function automatic void enter_phase(mss_pkg::phase_type next);
      phase = next;
      phase_elapsed = '0;
   endfunction

   function automatic void drop_held();
      result_held = 1'b0;
      held_systolic = '0;
      held_diastolic = '0;
      held_pulse_rate = '0;
   endfunction

   function automatic void advance_trigger();
      if (!pulse_active) begin
         pulse_active = 1'b1;
         pulse_elapsed = '0;
      end
      if (pulse_elapsed >= pulse_limit) begin
         pulse_active = 1'b0;
         enter_phase(mss_pkg::PH_MEASURING);
      end
   endfunction

   function automatic string beat_text(report_beat_type b);
      return $sformatf("report %0d sys %0d dia %0d rate %0d fault %0d phase %0d trig %0b",
                       b.report, b.systolic, b.diastolic, b.pulse_rate, b.fault, b.phase,
                       b.trigger_low);
   endfunction

   function automatic report_beat_type session_report(mss_pkg::op_type op,
                                                     logic [mss_pkg::VALUE_BITS-1:0] sys,
                                                     logic [mss_pkg::VALUE_BITS-1:0] dia,
                                                     logic [mss_pkg::VALUE_BITS-1:0] rate,
                                                     logic signed [mss_pkg::FAULT_BITS-1:0] code);
      report_beat_type beat;
      logic            show;
      beat = '0;
      beat.report = mss_pkg::REP_NONE;
      show = 1'b0;
      case (op)
         mss_pkg::OP_TICK: begin
            if (phase_elapsed != '1) phase_elapsed = phase_elapsed + 1'b1;
            if (pulse_active && pulse_elapsed != '1) pulse_elapsed = pulse_elapsed + 1'b1;
            if (phase == mss_pkg::PH_TRIGGER) advance_trigger();
            if (phase == mss_pkg::PH_MEASURING && phase_elapsed >= measure_limit) begin
               pulse_active = 1'b0;
               beat.report = mss_pkg::REP_ERROR;
               beat.fault = mss_pkg::FAULT_SILENT;
               enter_phase(mss_pkg::PH_IDLE);
            end else if (phase == mss_pkg::PH_SHUTDOWN && phase_elapsed >= shutdown_limit) begin
               beat.report = mss_pkg::REP_READY;
               result_held = 1'b0;
               enter_phase(mss_pkg::PH_IDLE);
            end
         end
         mss_pkg::OP_START: begin
            if (phase == mss_pkg::PH_IDLE || phase == mss_pkg::PH_DONE) begin
               drop_held();
               enter_phase(mss_pkg::PH_TRIGGER);
               advance_trigger();
            end else begin
               beat.report = mss_pkg::REP_NOTREADY;
            end
         end
         mss_pkg::OP_RESET: begin
            pulse_active = 1'b0;
            drop_held();
            enter_phase(mss_pkg::PH_IDLE);
            beat.report = mss_pkg::REP_READY;
         end
         mss_pkg::OP_STATUS: begin
            beat.report = mss_pkg::REP_STATUS;
         end
         mss_pkg::OP_RESULT: begin
            if (phase == mss_pkg::PH_MEASURING && !result_held) begin
               held_systolic = sys;
               held_diastolic = dia;
               held_pulse_rate = rate;
               result_held = 1'b1;
            end
         end
         mss_pkg::OP_DONE: begin
            if (phase == mss_pkg::PH_MEASURING) begin
               if (result_held) begin
                  beat.report = mss_pkg::REP_RESULT;
                  show = 1'b1;
               end else begin
                  beat.report = mss_pkg::REP_NORESULT;
               end
               enter_phase(mss_pkg::PH_SHUTDOWN);
            end
         end
         mss_pkg::OP_ERROR: begin
            if (phase == mss_pkg::PH_MEASURING && code != '0) begin
               beat.report = mss_pkg::REP_ERROR;
               beat.fault = code;
               enter_phase(mss_pkg::PH_SHUTDOWN);
            end
         end
         default: begin
            if (phase == mss_pkg::PH_SHUTDOWN) begin
               beat.report = mss_pkg::REP_READY;
               result_held = 1'b0;
               enter_phase(mss_pkg::PH_DONE);
            end
         end
      endcase
      if (show) begin
         beat.systolic = held_systolic;
         beat.diastolic = held_diastolic;
         beat.pulse_rate = held_pulse_rate;
      end
      beat.phase = phase;
      beat.trigger_low = pulse_active;
      return beat;
   endfunction

   always @(posedge clock) begin : watch
      report_beat_type want;
      report_beat_type got;
      if (reset) begin
         expected_reports.delete();
         pulse_limit = mss_pkg::PULSE_TICKS_RESET;
         measure_limit = mss_pkg::MEASURE_TIMEOUT_RESET;
         shutdown_limit = mss_pkg::SHUTDOWN_TIMEOUT_RESET;
         phase = mss_pkg::PH_IDLE;
         phase_elapsed = '0;
         pulse_active = 1'b0;
         pulse_elapsed = '0;
         drop_held();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.report = mss_pkg::report_type'(rsp_bus.report);
            got.systolic = rsp_bus.systolic_out;
            got.diastolic = rsp_bus.diastolic_out;
            got.pulse_rate = rsp_bus.pulse_rate_out;
            got.fault = rsp_bus.fault_code_out;
            got.phase = mss_pkg::phase_type'(rsp_bus.phase_out);
            got.trigger_low = rsp_bus.trigger_low;
            if (expected_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("report beat with none expected: report %0d phase %0d",
                           got.report, got.phase);
            end else begin
               want = expected_reports.pop_front();
               if (got.report !== want.report || got.systolic !== want.systolic ||
                   got.diastolic !== want.diastolic || got.pulse_rate !== want.pulse_rate ||
                   got.fault !== want.fault || got.phase !== want.phase ||
                   got.trigger_low !== want.trigger_low) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("expected %s", beat_text(want));
                     $display("  actual %s", beat_text(got));
                  end
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_reports.push_back(session_report(mss_pkg::op_type'(req_bus.operation),
                                                      req_bus.systolic_in,
                                                      req_bus.diastolic_in,
                                                      req_bus.pulse_rate_in,
                                                      req_bus.fault_code_in));
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.reg_index)
               mss_pkg::CSR_PULSE_TICKS:
                  pulse_limit = csr_bus.wr_data[mss_pkg::PULSE_BITS-1:0];
               mss_pkg::CSR_MEASURE_TIMEOUT:  measure_limit = csr_bus.wr_data;
               mss_pkg::CSR_SHUTDOWN_TIMEOUT: shutdown_limit = csr_bus.wr_data;
               default: ;
            endcase
         end
      end
      pending = expected_reports.size();
   end

endmodule

FILE: tb/tb_top.sv
// top of the measurement session sequencer testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned TIMER_BITS  = 20;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic [mss_pkg::CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned mismatch_count;
   int unsigned pending_reports;
   int unsigned cycle_count = 0;
   int          items_sent = 0;
   int          req_idle_pct = 0;
   int          rsp_idle_pct = 0;
   bit          rsp_long_hold = 1'b0;
   int unsigned pulse_cfg = 32'(mss_pkg::PULSE_TICKS_RESET);
   int unsigned measure_cfg = 32'(mss_pkg::MEASURE_TIMEOUT_RESET);
   int unsigned shutdown_cfg = 32'(mss_pkg::SHUTDOWN_TIMEOUT_RESET);

   mss_req_if req_bus();
   mss_rsp_if rsp_bus();
   mss_csr_if csr_bus();

   measurement_session_sequencer #(.TIMER_BITS(TIMER_BITS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   mss_session_checker #(.TIMER_BITS(TIMER_BITS)) session_check (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .csr_bus         (csr_bus),
      .mismatch_count  (mismatch_count),
      .pending_reports (pending_reports)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("measurement_session_sequencer regression: fail");
         $finish;
      end
   end

   function automatic int idle_gap(int pct);
      int pick;
      if ($urandom_range(0, 99) >= pct) return 0;
      pick = $urandom_range(0, 19);
      if (pick < 14) return $urandom_range(1, 2);
      if (pick < 19) return $urandom_range(3, 6);
      return $urandom_range(10, 40);
   endfunction

   initial begin : rsp_drain
      int idle_left;
      bit hold_served;
      idle_left = 0;
      hold_served = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_long_hold && !hold_served) begin
            hold_served = 1'b1;
            idle_left = 60;
         end
         if (idle_left > 0) begin
            rsp_bus.ready <= 1'b0;
            idle_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            idle_left = idle_gap(rsp_idle_pct);
         end
      end
   end

   task automatic send_event(mss_pkg::op_type op, logic [mss_pkg::VALUE_BITS-1:0] sys,
                             logic [mss_pkg::VALUE_BITS-1:0] dia,
                             logic [mss_pkg::VALUE_BITS-1:0] rate,
                             logic signed [mss_pkg::FAULT_BITS-1:0] code);
      int gap;
      gap = idle_gap(req_idle_pct);
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.systolic_in <= sys;
      req_bus.diastolic_in <= dia;
      req_bus.pulse_rate_in <= rate;
      req_bus.fault_code_in <= code;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_op(mss_pkg::op_type op);
      send_event(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
   endtask

   task automatic drain_reports();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_reports != 0) @(negedge clock);
   endtask

   task automatic write_reg(logic [mss_pkg::CSR_IDX_BITS-1:0] idx,
                            logic [mss_pkg::TIMEOUT_BITS-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wr_data <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      case (idx)
         mss_pkg::CSR_PULSE_TICKS:      pulse_cfg = 32'(data[mss_pkg::PULSE_BITS-1:0]);
         mss_pkg::CSR_MEASURE_TIMEOUT:  measure_cfg = 32'(data);
         mss_pkg::CSR_SHUTDOWN_TIMEOUT: shutdown_cfg = 32'(data);
         default: ;
      endcase
   endtask

   task automatic maybe_noise();
      if ($urandom_range(0, 9) == 0) send_op(mss_pkg::op_type'(3'($urandom_range(0, 7))));
   endtask

   task automatic run_session();
      mss_pkg::op_type mix [3] = '{mss_pkg::OP_TICK, mss_pkg::OP_RESULT, mss_pkg::OP_STATUS};
      int                                    pick;
      logic signed [mss_pkg::FAULT_BITS-1:0] code;
      send_op(mss_pkg::OP_START);
      repeat (pulse_cfg) begin
         maybe_noise();
         send_op(mss_pkg::OP_TICK);
      end
      repeat ($urandom_range(0, 3)) send_op(mix[2'($urandom_range(0, 2))]);
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
         send_op(mss_pkg::OP_DONE);
      end else if (pick <= 7) begin
         code = ($urandom_range(0, 7) == 0) ? '0 : 16'($urandom_range(0, 65535));
         send_event(mss_pkg::OP_ERROR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), code);
      end else if (pick == 8) begin
         repeat (measure_cfg + 1) send_op(mss_pkg::OP_TICK);
      end else begin
         send_op(mss_pkg::OP_RESET);
      end
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
         send_op(mss_pkg::OP_POWERDOWN);
      end else if (pick <= 8) begin
         repeat (shutdown_cfg + 1) send_op(mss_pkg::OP_TICK);
      end else begin
         send_op(mss_pkg::OP_START);
         send_op(mss_pkg::OP_POWERDOWN);
      end
      maybe_noise();
   endtask

   initial begin : stimulus
      int phase_no;
      int target;
      req_bus.valid = 1'b0;
      req_bus.operation = mss_pkg::OP_TICK;
      req_bus.systolic_in = '0;
      req_bus.diastolic_in = '0;
      req_bus.pulse_rate_in = '0;
      req_bus.fault_code_in = '0;
      csr_bus.valid = 1'b0;
      csr_bus.reg_index = mss_pkg::CSR_PULSE_TICKS;
      csr_bus.wr_data = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // register defaults: events out of phase, busy start, reset in trigger
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      send_op(mss_pkg::OP_STATUS);
      send_op(mss_pkg::OP_TICK);
      send_event(mss_pkg::OP_RESULT, 8'd255, 8'd255, 8'd255, '0);
      send_op(mss_pkg::OP_DONE);
      send_event(mss_pkg::OP_ERROR, 8'd0, 8'd0, 8'd0, 16'sh7FFF);
      send_op(mss_pkg::OP_POWERDOWN);
      send_op(mss_pkg::OP_START);
      send_op(mss_pkg::OP_START);
      send_op(mss_pkg::OP_RESET);

      // zero pulse and zero watchdog limits
      drain_reports();
      write_reg(mss_pkg::CSR_PULSE_TICKS, 20'hF0000);
      write_reg(mss_pkg::CSR_MEASURE_TIMEOUT, 20'h00000);
      write_reg(mss_pkg::CSR_SHUTDOWN_TIMEOUT, 20'h00000);
      send_op(mss_pkg::OP_START);
      send_event(mss_pkg::OP_RESULT, 8'd0, 8'd0, 8'd0, '0);
      send_event(mss_pkg::OP_RESULT, 8'd255, 8'd255, 8'd255, '0);
      send_op(mss_pkg::OP_DONE);
      send_op(mss_pkg::OP_TICK);
      send_op(mss_pkg::OP_START);
      send_op(mss_pkg::OP_TICK);
      send_op(mss_pkg::OP_START);
      send_event(mss_pkg::OP_ERROR, 8'd0, 8'd0, 8'd0, '0);
      send_event(mss_pkg::OP_ERROR, 8'd0, 8'd0, 8'd0, 16'sh8000);
      send_op(mss_pkg::OP_DONE);
      send_op(mss_pkg::OP_START);
      send_op(mss_pkg::OP_POWERDOWN);
      send_op(mss_pkg::OP_START);
      send_event(mss_pkg::OP_RESULT, 8'd255, 8'd255, 8'd255, '0);
      send_op(mss_pkg::OP_DONE);
      send_op(mss_pkg::OP_RESET);

      // largest limits and the unused register index
      drain_reports();
      write_reg(mss_pkg::CSR_PULSE_TICKS, 20'hFFFFF);
      write_reg(mss_pkg::CSR_MEASURE_TIMEOUT, 20'hFFFFF);
      write_reg(mss_pkg::CSR_SHUTDOWN_TIMEOUT, 20'hFFFFF);
      write_reg(CSR_SPARE, 20'($urandom_range(0, 20'hFFFFF)));
      send_op(mss_pkg::OP_START);
      send_op(mss_pkg::OP_TICK);
      send_op(mss_pkg::OP_TICK);
      send_op(mss_pkg::OP_STATUS);
      send_op(mss_pkg::OP_START);
      send_op(mss_pkg::OP_RESET);

      for (phase_no = 0; phase_no < 5; phase_no++) begin
         drain_reports();
         write_reg(mss_pkg::CSR_PULSE_TICKS, 20'($urandom_range(0, 4)));
         write_reg(mss_pkg::CSR_MEASURE_TIMEOUT, 20'($urandom_range(0, 40)));
         write_reg(mss_pkg::CSR_SHUTDOWN_TIMEOUT, 20'($urandom_range(0, 40)));
         req_idle_pct = (phase_no == 0) ? 0 : $urandom_range(10, 50);
         rsp_idle_pct = (phase_no == 0) ? 0 : $urandom_range(10, 50);
         if (phase_no == 1) begin
            req_idle_pct = 0;
            rsp_long_hold = 1'b1;
         end
         target = items_sent + 110;
         while (items_sent < target) run_session();
      end

      drain_reports();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pending_reports == 0)
         $display("measurement_session_sequencer regression: pass");
      else
         $display("measurement_session_sequencer regression: fail");
      $finish;
   end

endmodule
